// ===== hw/rtl/hsvrgb_pkg.sv =====
// Constants and types shared by the HSV/HSL to RGB conversion pipeline.
package hsvrgb_pkg;

    // Field widths of the stream words.
    localparam int HUE_W      = 15;
    localparam int BYTE_W     = 8;
    localparam int IN_DATA_W  = 32;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;

    // Bit positions in the input tuser.
    localparam int USER_MODE  = 0;
    localparam int USER_KNOWN = 1;

    // Hue is fixed point with this many fraction bits per degree.
    localparam int HUE_FRAC_BITS = 6;
    localparam int PER_SECTOR    = 60 << HUE_FRAC_BITS;
    localparam int FULL_TURN     = 6 * PER_SECTOR;
    localparam int PS_W          = $clog2(PER_SECTOR + 1);
    localparam int TURN_W        = $clog2(FULL_TURN + 1);
    localparam int HUE_CW        = (TURN_W > HUE_W) ? TURN_W : HUE_W;

    // Twice chroma and the offset, in units of 1/(2*255*255).
    localparam int CM_W = 18;

    // Channel numerator before the final division, rounding bias included.
    localparam longint CM_MAX  = 2 * 255 * 255;
    localparam longint SUM_MAX = (2 * CM_MAX + 255) * PER_SECTOR;
    localparam int     V_W     = $clog2(SUM_MAX + 1);

    // Exact division by the channel denominator through a ceiling reciprocal.
    localparam longint   DEN   = 510 * PER_SECTOR;
    localparam int       SHIFT = V_W + $clog2(DEN) + 1;
    localparam logic [63:0] RECIP = ((64'd1 << SHIFT) + 64'(DEN) - 64'd1) / 64'(DEN);
    localparam int       R_W   = $clog2(RECIP + 64'd1);
    localparam int       P_W   = V_W + R_W;
    localparam int       Q_W   = P_W - SHIFT;

    typedef logic [2:0] sector_t;

endpackage

// ===== hw/rtl/hsv_hsl_to_rgb.sv =====
// Top level of the five-stage HSV/HSL to RGB pixel conversion pipeline.
//
// Usage: pixels enter on the s_axis channel and leave as RGB bytes on the
// m_axis channel. tuser bit 0 picks the color model (0 = HSV, 1 = HSL) and
// bit 1 says whether the hue is known; an unknown hue or one of 360 degrees
// or more gives grey. Hue is in 1/64 degree, saturation and level in 1/255.
// Throughput is one word per cycle while m_axis_tready is high: each of the
// five register stages holds one word, and the stage multipliers are all
// combinational.
// Reset clears the valid bit of every stage, so the pipeline comes up empty
// and ready. When the receiver drops m_axis_tready the output word holds;
// each earlier stage keeps moving as long as the stage after it is empty,
// so bubbles are squeezed out and input is taken until the pipeline is full.
// No word is dropped or repeated during a stall.
module hsv_hsl_to_rgb (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // hue[14:0], saturation[22:15], level[30:23], zero[31]
    input  logic [hsvrgb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // mode[0], hue_known[1]
    input  logic [hsvrgb_pkg::IN_USER_W-1:0]   s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // red[7:0], green[15:8], blue[23:16]
    output logic [hsvrgb_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import hsvrgb_pkg::*;

    localparam int STAGES = 5;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   ready;

    // Stage 1: chroma, offset, hue sector and position in the sector.
    logic              mode;
    logic              hue_known;
    logic [HUE_W-1:0]  hue;
    logic [BYTE_W-1:0] sat;
    logic [BYTE_W-1:0] lvl;
    logic [8:0]        twol;
    logic [8:0]        lvl_dist;
    logic [7:0]        factor;
    logic [15:0]       chroma;
    logic [15:0]       lvl255;
    logic [HUE_CW-1:0] hue_ext;
    logic [PS_W-1:0]   rem;

    logic [CM_W-1:0]   c2_next,  c2_reg;
    logic [CM_W-1:0]   m2_next,  m2_reg;
    sector_t           sec1_next, sec1_reg;
    logic [PS_W-1:0]   t_next,   t_reg;
    logic              ok1_next, ok1_reg;

    // Stage 2: scaled offset, chroma and the in-between value.
    logic [V_W-1:0]    base_next, base_reg;
    logic [V_W-1:0]    cp_next,   cp_reg;
    logic [V_W-1:0]    xt_next,   xt_reg;
    sector_t           sec2_reg;
    logic              ok2_reg;

    // Stage 3: channel numerators.
    logic [V_W-1:0]    add_r, add_g, add_b;
    logic [V_W-1:0]    vr_next, vr_reg;
    logic [V_W-1:0]    vg_next, vg_reg;
    logic [V_W-1:0]    vb_next, vb_reg;

    // Stage 4: quotients.
    logic [P_W-1:0]    pr, pg, pb;
    logic [Q_W-1:0]    qr_reg, qg_reg, qb_reg;

    // Stage 5: output bytes.
    logic [BYTE_W-1:0] red_next, green_next, blue_next;
    logic [BYTE_W-1:0] red_reg,  green_reg,  blue_reg;

    // A stage may load when it is empty or its word moves on in this cycle.
    always_comb
    begin
        ready[STAGES] = m_axis_tready;
        for (int i = STAGES - 1; i >= 0; i--)
        begin
            ready[i] = ~valid_reg[i] | ready[i+1];
        end
    end

    assign s_axis_tready = ready[0];
    assign m_axis_tvalid = valid_reg[STAGES-1];
    assign m_axis_tdata  = {blue_reg, green_reg, red_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (ready[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    // ---------------- Stage 1 ----------------
    always_comb
    begin
        mode      = s_axis_tuser[USER_MODE];
        hue_known = s_axis_tuser[USER_KNOWN];
        hue       = s_axis_tdata[HUE_W-1:0];
        sat       = s_axis_tdata[HUE_W +: BYTE_W];
        lvl       = s_axis_tdata[HUE_W+BYTE_W +: BYTE_W];

        // Distance of lightness from its middle value, |2l - 255|.
        twol     = {lvl, 1'b0};
        lvl_dist = (twol >= 9'd255) ? (twol - 9'd255) : (9'd255 - twol);
        factor   = mode ? 8'(9'd255 - lvl_dist) : lvl;
        chroma   = 16'({8'd0, sat} * {8'd0, factor});
        lvl255   = 16'({8'd0, lvl} * 16'd255);

        c2_next = {1'b0, chroma, 1'b0};
        if (mode)
        begin
            m2_next = {1'b0, lvl255, 1'b0} - CM_W'(chroma);
        end
        else
        begin
            m2_next = {1'b0, 16'(lvl255 - chroma), 1'b0};
        end

        hue_ext   = HUE_CW'(hue);
        sec1_next = '0;
        for (int k = 1; k < 6; k++)
        begin
            if (hue_ext >= HUE_CW'(k * PER_SECTOR))
            begin
                sec1_next = sec1_next + 3'd1;
            end
        end
        rem      = PS_W'(hue_ext - HUE_CW'(HUE_CW'(sec1_next) * HUE_CW'(PER_SECTOR)));
        t_next   = sec1_next[0] ? (PS_W'(PER_SECTOR) - rem) : rem;
        ok1_next = hue_known && (hue_ext < HUE_CW'(FULL_TURN));
    end

    always_ff @(posedge clk)
    begin
        if (ready[0])
        begin
            c2_reg   <= c2_next;
            m2_reg   <= m2_next;
            sec1_reg <= sec1_next;
            t_reg    <= t_next;
            ok1_reg  <= ok1_next;
        end
    end

    // ---------------- Stage 2 ----------------
    always_comb
    begin
        base_next = V_W'(V_W'(V_W'(m2_reg) + V_W'(255)) * V_W'(PER_SECTOR));
        cp_next   = V_W'(V_W'(c2_reg) * V_W'(PER_SECTOR));
        xt_next   = V_W'(V_W'(c2_reg) * V_W'(t_reg));
    end

    always_ff @(posedge clk)
    begin
        if (ready[1])
        begin
            base_reg <= base_next;
            cp_reg   <= cp_next;
            xt_reg   <= xt_next;
            sec2_reg <= sec1_reg;
            ok2_reg  <= ok1_reg;
        end
    end

    // ---------------- Stage 3 ----------------
    // Hexcone placement: each channel gets chroma, the in-between value
    // or nothing on top of the offset.
    always_comb
    begin
        add_r = '0;
        add_g = '0;
        add_b = '0;
        if (ok2_reg)
        begin
            case (sec2_reg)
                3'd0:
                begin
                    add_r = cp_reg;
                    add_g = xt_reg;
                end
                3'd1:
                begin
                    add_r = xt_reg;
                    add_g = cp_reg;
                end
                3'd2:
                begin
                    add_g = cp_reg;
                    add_b = xt_reg;
                end
                3'd3:
                begin
                    add_g = xt_reg;
                    add_b = cp_reg;
                end
                3'd4:
                begin
                    add_r = xt_reg;
                    add_b = cp_reg;
                end
                default:
                begin
                    add_r = cp_reg;
                    add_b = xt_reg;
                end
            endcase
        end
        vr_next = base_reg + add_r;
        vg_next = base_reg + add_g;
        vb_next = base_reg + add_b;
    end

    always_ff @(posedge clk)
    begin
        if (ready[2])
        begin
            vr_reg <= vr_next;
            vg_reg <= vg_next;
            vb_reg <= vb_next;
        end
    end

    // ---------------- Stage 4 ----------------
    // The reciprocal is rounded up and wide enough that the truncated
    // product equals the exact floor quotient.
    always_comb
    begin
        pr = P_W'(vr_reg) * P_W'(RECIP[R_W-1:0]);
        pg = P_W'(vg_reg) * P_W'(RECIP[R_W-1:0]);
        pb = P_W'(vb_reg) * P_W'(RECIP[R_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (ready[3])
        begin
            qr_reg <= pr[SHIFT +: Q_W];
            qg_reg <= pg[SHIFT +: Q_W];
            qb_reg <= pb[SHIFT +: Q_W];
        end
    end

    // ---------------- Stage 5 ----------------
    always_comb
    begin
        red_next   = (qr_reg > Q_W'(255)) ? 8'hFF : qr_reg[BYTE_W-1:0];
        green_next = (qg_reg > Q_W'(255)) ? 8'hFF : qg_reg[BYTE_W-1:0];
        blue_next  = (qb_reg > Q_W'(255)) ? 8'hFF : qb_reg[BYTE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (ready[4])
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

endmodule

// ===== test/tb_hsv_hsl_to_rgb.sv =====
// Self-checking testbench for the HSV/HSL to RGB pixel conversion pipeline.
module tb_hsv_hsl_to_rgb;

    import hsvrgb_pkg::*;

    localparam bit  MODE_HSV    = 1'b0;
    localparam bit  MODE_HSL    = 1'b1;
    localparam int  RANDOM_PIXELS = 700;
    localparam int  CYCLE_LIMIT = 300000;
    localparam int  DRAIN_CYCLES = 20;
    localparam int  HOLDOFF_CYCLES = 80;
    localparam int  REPORT_CAP  = 200;
    localparam longint unsigned SECTOR_SPAN = 64'd60 << HUE_FRAC_BITS;
    localparam int  GREY_HUE    = 6 * (60 << HUE_FRAC_BITS);

    typedef struct packed {
        logic        mode;
        logic        known;
        logic [14:0] hue;
        logic [7:0]  sat;
        logic [7:0]  lvl;
    } pixel_t;

    // Same bit order as the output tdata: red in the lowest byte.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    pixel_t pixel_queue[$];
    rgb_t   rgb_expected[$];
    pixel_t offered;
    int     errors = 0;
    int     cycles = 0;
    int     burst_left = 0;
    int     gap_left = 0;
    logic   hold_active = 1'b0;

    hsv_hsl_to_rgb dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Divides a channel numerator by the common denominator, rounding half up.
    function automatic logic [7:0] scale_channel(longint unsigned num);
        longint unsigned q;
        q = (num + 255 * SECTOR_SPAN) / (510 * SECTOR_SPAN);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // All values are kept in units of 1/(2*255*255*SECTOR_SPAN), so nothing
    // rounds until the final division.
    function automatic rgb_t convert_pixel(pixel_t p);
        longint unsigned c, c2, m2, cn, mn, xn, r, g, b, sector, rem, twol, lvl_dist;
        rgb_t res;
        if (p.mode == MODE_HSV)
        begin
            c  = longint'(p.sat) * longint'(p.lvl);
            c2 = 2 * c;
            m2 = 2 * (255 * longint'(p.lvl) - c);
        end
        else
        begin
            twol     = 2 * longint'(p.lvl);
            lvl_dist = (twol >= 255) ? twol - 255 : 255 - twol;
            c        = longint'(p.sat) * (255 - lvl_dist);
            c2       = 2 * c;
            m2       = 2 * 255 * longint'(p.lvl) - c;
        end
        cn = c2 * SECTOR_SPAN;
        mn = m2 * SECTOR_SPAN;
        r = mn;
        g = mn;
        b = mn;
        sector = longint'(p.hue) / SECTOR_SPAN;
        rem    = longint'(p.hue) - sector * SECTOR_SPAN;
        if (p.known && sector < 6)
        begin
            xn = c2 * (sector[0] ? (SECTOR_SPAN - rem) : rem);
            case (sector)
                0: begin r += cn; g += xn; end
                1: begin r += xn; g += cn; end
                2: begin g += cn; b += xn; end
                3: begin g += xn; b += cn; end
                4: begin r += xn; b += cn; end
                default: begin r += cn; b += xn; end
            endcase
        end
        res.red   = scale_channel(r);
        res.green = scale_channel(g);
        res.blue  = scale_channel(b);
        return res;
    endfunction

    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 8'd0;
        else if (sel == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic pixel_t pick_pixel();
        pixel_t p;
        int sel;
        p.mode  = 1'($urandom_range(0, 1));
        p.known = ($urandom_range(0, 9) != 0);
        sel = $urandom_range(0, 19);
        if (sel < 15)
            p.hue = 15'($urandom_range(0, GREY_HUE - 1));
        else if (sel < 17)
            p.hue = 15'(int'($urandom_range(1, 6)) * int'(SECTOR_SPAN)
                        + int'($urandom_range(0, 2)) - 1);
        else
            p.hue = 15'($urandom_range(GREY_HUE, 32767));
        p.sat = pick_byte();
        p.lvl = pick_byte();
        return p;
    endfunction

    function automatic pixel_t make_pixel(bit mode, bit known, int hue, int sat, int lvl);
        pixel_t p;
        p.mode  = mode;
        p.known = known;
        p.hue   = 15'(hue);
        p.sat   = 8'(sat);
        p.lvl   = 8'(lvl);
        return p;
    endfunction

    // Sender: bursts of words separated by gaps; a word that is offered is
    // held until it is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                rgb_expected.push_back(convert_pixel(offered));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (gap_left > 0 && !hold_active)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (pixel_queue.size() > 0)
                begin
                    offered = pixel_queue.pop_front();
                    s_axis_tdata  <= {1'b0, offered.lvl, offered.sat, offered.hue};
                    s_axis_tuser  <= {offered.known, offered.mode};
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: stall style changes from phase to phase, plus one long hold-off
    // that lets the pipeline fill and push back on the sender.
    int  phase_left = 0;
    int  phase_style = 0;
    int  words_taken = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  toggle = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_active   <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                words_taken++;
            if (!hold_done && words_taken >= 150)
            begin
                hold_done = 1'b1;
                hold_left = HOLDOFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                hold_active   <= 1'b1;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                hold_active <= 1'b0;
                if (phase_left == 0)
                begin
                    phase_left  = $urandom_range(1, 40);
                    phase_style = $urandom_range(0, 3);
                end
                phase_left--;
                toggle = ~toggle;
                case (phase_style)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= toggle;
                endcase
            end
        end
    end

    // Checks every word taken from the pipeline against the oldest prediction.
    always @(posedge clk)
    begin
        rgb_t want;
        rgb_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (rgb_expected.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_CAP)
                    $display("%0t: unexpected word, expected none, actual %h", $time, got);
            end
            else
            begin
                want = rgb_expected.pop_front();
                if (got.red !== want.red)
                begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $display("%0t: red expected %h actual %h", $time, want.red, got.red);
                end
                if (got.green !== want.green)
                begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $display("%0t: green expected %h actual %h",
                                 $time, want.green, got.green);
                end
                if (got.blue !== want.blue)
                begin
                    errors++;
                    if (errors <= REPORT_CAP)
                        $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("hsv_hsl_to_rgb: mismatch");
            $finish;
        end
    end

    initial
    begin
        int span;
        span = int'(SECTOR_SPAN);
        // Extremes of every field, both models, sector edges, grey cases.
        pixel_queue.push_back(make_pixel(MODE_HSV, 1'b1, 0, 255, 255));
        pixel_queue.push_back(make_pixel(MODE_HSL, 1'b1, 0, 255, 128));
        pixel_queue.push_back(make_pixel(MODE_HSV, 1'b1, 0, 0, 0));
        pixel_queue.push_back(make_pixel(MODE_HSL, 1'b1, 0, 0, 255));
        pixel_queue.push_back(make_pixel(MODE_HSV, 1'b1, span - 1, 255, 255));
        pixel_queue.push_back(make_pixel(MODE_HSV, 1'b1, span, 255, 255));
        pixel_queue.push_back(make_pixel(MODE_HSL, 1'b1, 2 * span, 200, 127));
        pixel_queue.push_back(make_pixel(MODE_HSV, 1'b1, 3 * span + 1, 128, 200));
        pixel_queue.push_back(make_pixel(MODE_HSL, 1'b1, 4 * span, 255, 64));
        pixel_queue.push_back(make_pixel(MODE_HSV, 1'b1, 5 * span, 255, 255));
        pixel_queue.push_back(make_pixel(MODE_HSL, 1'b1, GREY_HUE - 1, 255, 128));
        pixel_queue.push_back(make_pixel(MODE_HSV, 1'b1, GREY_HUE, 255, 255));
        pixel_queue.push_back(make_pixel(MODE_HSL, 1'b1, GREY_HUE, 100, 200));
        pixel_queue.push_back(make_pixel(MODE_HSV, 1'b1, 32767, 255, 255));
        pixel_queue.push_back(make_pixel(MODE_HSL, 1'b1, 32767, 255, 0));
        pixel_queue.push_back(make_pixel(MODE_HSV, 1'b0, 1000, 255, 255));
        pixel_queue.push_back(make_pixel(MODE_HSV, 1'b0, 5000, 128, 200));
        pixel_queue.push_back(make_pixel(MODE_HSL, 1'b0, 9000, 200, 100));
        pixel_queue.push_back(make_pixel(MODE_HSL, 1'b0, 32767, 255, 255));
        pixel_queue.push_back(make_pixel(MODE_HSV, 1'b1, 7000, 0, 173));
        pixel_queue.push_back(make_pixel(MODE_HSL, 1'b1, 15000, 0, 90));
        pixel_queue.push_back(make_pixel(MODE_HSL, 1'b1, 16384, 255, 255));
        pixel_queue.push_back(make_pixel(MODE_HSV, 1'b1, 21845, 170, 85));
        repeat (RANDOM_PIXELS)
            pixel_queue.push_back(pick_pixel());

        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (pixel_queue.size() != 0 || s_axis_tvalid || rgb_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("hsv_hsl_to_rgb: match");
        else
            $display("hsv_hsl_to_rgb: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/hsvrgb_pkg.sv
hw/rtl/hsv_hsl_to_rgb.sv
test/tb_hsv_hsl_to_rgb.sv
